### design/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants for the Sobel gradient magnitude block
// Configuration register map, fixed field widths, and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int WCFG_W     = 11;
  localparam int ROW_W      = 12;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ZERO_BORDER  = 2'd2
  } cfg_reg_t;

  // Register reset values
  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_W-1:0]  HEIGHT_RESET = 12'd1024;
  localparam logic              BORDER_RESET = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic shift;
    logic grad_load;
    logic sq_load;
    logic root_step;
    logic out_load;
  } sgm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;
    logic root_last;
    logic out_full;
  } sgm_sts_t;

endpackage

`default_nettype wire

### design/sgm_ifs.sv
// ----------------------------------------------------------------------------
// sgm_ifs: channel interfaces of the Sobel gradient magnitude block
// Pixel input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgm_pix_if #(parameter int PIXEL_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;
  logic                  frame_start;
  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

interface sgm_res_if #(parameter int PIXEL_BITS = 8, parameter int COL_W = 10);
  import sgm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS+2:0] grad_x;
  logic signed [PIXEL_BITS+2:0] grad_y;
  logic        [PIXEL_BITS+2:0] magnitude;
  logic        [ROW_W-1:0]      centre_row;
  logic        [COL_W-1:0]      centre_col;
  modport source (output valid, grad_x, grad_y, magnitude, centre_row, centre_col,
                  input ready);
  modport sink   (input valid, grad_x, grad_y, magnitude, centre_row, centre_col,
                  output ready);
endinterface

interface sgm_cfg_if;
  import sgm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/sgm_ram.sv
// ----------------------------------------------------------------------------
// sgm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/sgm_ctrl.sv
// ----------------------------------------------------------------------------
// sgm_ctrl: sequencer of the Sobel gradient magnitude block
// Steps each pixel through line read and window shift; a pixel with a result
// then goes through gradient, square and the iterative root to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_ready,
  output sgm_pkg::sgm_cmd_t cmd,
  input  sgm_pkg::sgm_sts_t sts
);
  import sgm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_GRAD   = 6'b000100,
    S_SQUARE = 6'b001000,
    S_ROOT   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    pix_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        pix_ready  = 1'b1;
        cmd.accept = pix_valid;
        if (pix_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.shift  = 1'b1;
        state_next = sts.has_result ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad_load = 1'b1;
        state_next    = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.sq_load = 1'b1;
        state_next  = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/sgm_datapath.sv
// ----------------------------------------------------------------------------
// sgm_datapath: datapath of the Sobel gradient magnitude block
// Position counters, border zeroing, line store, 3x3 window, gradients,
// digit-by-digit square root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_datapath #(
  parameter  int MAX_WIDTH  = 1024,
  parameter  int PIXEL_BITS = 8,
  localparam int COL_W      = $clog2(MAX_WIDTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sgm_pkg::sgm_cmd_t               cmd,
  output sgm_pkg::sgm_sts_t               sts,
  input  logic                            cfg_write,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [PIXEL_BITS-1:0]           pixel_value,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [PIXEL_BITS+2:0]    grad_x,
  output logic signed [PIXEL_BITS+2:0]    grad_y,
  output logic        [PIXEL_BITS+2:0]    magnitude,
  output logic        [sgm_pkg::ROW_W-1:0] centre_row,
  output logic        [COL_W-1:0]         centre_col
);
  import sgm_pkg::*;

  localparam int G_W        = PIXEL_BITS + 3;
  localparam int SQ_W       = 2 * G_W;
  localparam int REM_W      = G_W + 2;
  localparam int ROOT_STEPS = G_W;
  localparam int CNT_W      = $clog2(ROOT_STEPS);
  localparam int EXT_W      = (COL_W + 1 > WCFG_W) ? COL_W + 1 : WCFG_W;

  // Configuration registers
  logic [WCFG_W-1:0] width_cfg;
  logic [ROW_W-1:0]  height_cfg;
  logic              border_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= WIDTH_RESET;
      height_cfg <= HEIGHT_RESET;
      border_cfg <= BORDER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_cfg  <= cfg_data[WCFG_W-1:0];
        REG_IMAGE_HEIGHT: height_cfg <= cfg_data[ROW_W-1:0];
        REG_ZERO_BORDER:  border_cfg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size in use
  logic [EXT_W-1:0] w_ext, w_use;
  logic [ROW_W-1:0] h_use;

  always_comb begin
    w_ext = EXT_W'(width_cfg);
    if (w_ext < EXT_W'(3)) begin
      w_use = EXT_W'(3);
    end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
      w_use = EXT_W'(MAX_WIDTH);
    end else begin
      w_use = w_ext;
    end
    h_use = (height_cfg < ROW_W'(3)) ? ROW_W'(3) : height_cfg;
  end

  // Position of the incoming pixel
  logic [ROW_W-1:0]      row_count, col_dummy_row;
  logic [COL_W-1:0]      col_count;
  logic [ROW_W-1:0]      row_in, row_inc;
  logic [COL_W-1:0]      col_in;
  logic [EXT_W-1:0]      col_inc;
  logic                  on_border;
  logic [PIXEL_BITS-1:0] px_in;

  always_comb begin
    row_in = row_count;
    col_in = col_count;
    if (frame_start) begin
      row_in = '0;
      col_in = '0;
    end else begin
      if (EXT_W'(col_count) >= w_use) begin
        col_in = '0;
        row_in = row_count + ROW_W'(1);
      end
      if (row_in >= h_use) begin
        row_in = '0;
      end
    end
    on_border = (row_in == '0) || (row_in == h_use - ROW_W'(1)) ||
                (col_in == '0) || (EXT_W'(col_in) == w_use - EXT_W'(1));
    px_in     = (border_cfg && on_border) ? '0 : pixel_value;
    col_inc   = EXT_W'(col_in) + EXT_W'(1);
    row_inc   = row_in + ROW_W'(1);
    col_dummy_row = (row_inc >= h_use) ? '0 : row_inc;
  end

  // Advance the counters and capture the item
  logic [ROW_W-1:0]      cur_row;
  logic [COL_W-1:0]      cur_col;
  logic [PIXEL_BITS-1:0] cur_px;
  logic                  has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      col_count  <= '0;
      has_result <= 1'b0;
    end else if (cmd.accept) begin
      if (col_inc >= w_use) begin
        col_count <= '0;
        row_count <= col_dummy_row;
      end else begin
        col_count <= col_inc[COL_W-1:0];
        row_count <= row_in;
      end
      has_result <= (row_in >= ROW_W'(2)) && (col_in >= COL_W'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_row <= row_in;
      cur_col <= col_in;
      cur_px  <= px_in;
    end
  end

  // Line store: upper half top row, lower half middle row
  logic [2*PIXEL_BITS-1:0] line_rd;

  sgm_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (cmd.shift),
    .wr_addr (cur_col),
    .wr_data ({line_rd[PIXEL_BITS-1:0], cur_px}),
    .rd_en   (cmd.accept),
    .rd_addr (col_in),
    .rd_data (line_rd)
  );

  // 3x3 window, column 2 is the newest
  logic [PIXEL_BITS-1:0] win [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
      win[1][2] <= line_rd[PIXEL_BITS-1:0];
      win[2][2] <= cur_px;
    end
  end

  // Gradients, modulo 2^G_W which covers the full range
  logic [G_W-1:0]        gx_c, gy_c;
  logic signed [G_W-1:0] gx_r, gy_r;

  always_comb begin
    gx_c = (G_W'(win[0][0]) + (G_W'(win[1][0]) << 1) + G_W'(win[2][0])) -
           (G_W'(win[0][2]) + (G_W'(win[1][2]) << 1) + G_W'(win[2][2]));
    gy_c = (G_W'(win[0][0]) + (G_W'(win[0][1]) << 1) + G_W'(win[0][2])) -
           (G_W'(win[2][0]) + (G_W'(win[2][1]) << 1) + G_W'(win[2][2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.grad_load) begin
      gx_r <= gx_c;
      gy_r <= gy_c;
    end
  end

  // Sum of squares and digit-by-digit root, two radicand bits per step
  logic signed [SQ_W-1:0] sqx, sqy;
  logic [SQ_W-1:0]        sq;
  logic [REM_W-1:0]       rem, rem_sh, trial;
  logic [G_W-1:0]         rt;
  logic [CNT_W-1:0]       cnt;

  assign sqx    = SQ_W'(gx_r) * SQ_W'(gx_r);
  assign sqy    = SQ_W'(gy_r) * SQ_W'(gy_r);
  assign rem_sh = {rem[REM_W-3:0], sq[SQ_W-1:SQ_W-2]};
  assign trial  = {rt, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq  <= unsigned'(sqx) + unsigned'(sqy);
      rem <= '0;
      rt  <= '0;
      cnt <= CNT_W'(ROOT_STEPS - 1);
    end else if (cmd.root_step) begin
      sq  <= sq << 2;
      cnt <= cnt - CNT_W'(1);
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        rt  <= {rt[G_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        rt  <= {rt[G_W-2:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      grad_x     <= gx_r;
      grad_y     <= gy_r;
      magnitude  <= rt;
      centre_row <= cur_row - ROW_W'(1);
      centre_col <= cur_col - COL_W'(1);
    end
  end

  // Status
  always_comb begin
    sts.has_result = has_result;
    sts.root_last  = (cnt == '0);
    sts.out_full   = out_valid;
  end

endmodule

`default_nettype wire

### design/sobel_gradient_magnitude_top.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_top: Sobel 3x3 edge detector
// Raster pixel stream in, gradients, magnitude and centre position out.
// ----------------------------------------------------------------------------
// Usage:
//   pix  - pixel input, one grey pixel per transaction in raster order;
//          frame_start marks row 0, column 0 of a frame.
//   res  - one result transaction per pixel whose row and column are both
//          at least 2: grad_x, grad_y, floor(sqrt(gx^2+gy^2)) and the
//          window centre (row-1, col-1).
//   cfg  - register writes (0 image_width, 1 image_height, 2 zero_border),
//          always ready; write only while the block is idle.
//   Throughput: one pixel at a time. A pixel with no result goes from line read
//   and window shift straight back to idle; a pixel with a result also passes
//   gradient, square and the square root unit, which resolves one result bit
//   per cycle, before it loads a free output register.
//   The output register holds a finished result while the receiver stalls;
//   the next pixel is taken meanwhile and its result waits in the datapath.
//   Reset clears counters, window and registers to their defaults; the line
//   store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_magnitude_top #(
  parameter  int MAX_WIDTH  = 1024,
  parameter  int PIXEL_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  sgm_pix_if.sink   pix,
  sgm_res_if.source res,
  sgm_cfg_if.sink   cfg
);
  import sgm_pkg::*;

  sgm_cmd_t cmd;
  sgm_sts_t sts;

  assign cfg.ready = 1'b1;

  sgm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sgm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_write   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .pixel_value (pix.pixel_value),
    .frame_start (pix.frame_start),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .grad_x      (res.grad_x),
    .grad_y      (res.grad_y),
    .magnitude   (res.magnitude),
    .centre_row  (res.centre_row),
    .centre_col  (res.centre_col)
  );

`ifndef SYNTH
  // One pixel in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> !pix.ready)
    else $error("pixel accepted while previous one in flight");

  // Magnitude is at least each gradient's absolute value
  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ($signed({1'b0, res.magnitude}) >= res.grad_x) &&
                  ($signed({1'b0, res.magnitude}) >= -res.grad_x) &&
                  ($signed({1'b0, res.magnitude}) >= res.grad_y) &&
                  ($signed({1'b0, res.magnitude}) >= -res.grad_y))
    else $error("magnitude below gradient");

  // Result only loads into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !res.valid)
    else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

### tb/sv/sobel_gradient_magnitude_top_tb.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_top_tb: self-checking bench for the Sobel block
// Streams raster pixels through the pixel channel with random gaps. A local
// line-buffer and window model predicts every gradient result, and the
// predictions are compared field by field against the result channel, which
// stalls at random and once holds off for a long stretch. Several register
// settings are exercised, including clamped and full-width extremes.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_top_tb;
  import sgm_pkg::*;

  typedef struct {
    logic [7:0] px;
    bit         fs;
  } pixel_t;

  typedef struct {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [10:0]        mag;
    logic [11:0]        row;
    logic [9:0]         col;
  } grad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgm_pix_if #(.PIXEL_BITS(8)) pix_ch();
  sgm_res_if #(.PIXEL_BITS(8), .COL_W(10)) res_ch();
  sgm_cfg_if cfg_ch();

  sobel_gradient_magnitude_top dut (
    .clk(clk), .rst(rst), .pix(pix_ch), .res(res_ch), .cfg(cfg_ch)
  );

  pixel_t pixel_q[$];
  grad_t  grad_q[$];
  int     errors = 0;
  bit     quiet = 1'b0;
  logic   hold = 1'b0;
  int     pix_gap = 0;
  int     res_stall = 0;

  // Local copy of the block state and registers
  int          width_reg = 1024;
  int          height_reg = 1024;
  bit          border_reg = 1'b1;
  logic [7:0]  line_top[1024];
  logic [7:0]  line_mid[1024];
  logic [7:0]  win[3][3];
  int          row_cnt = 0;
  int          col_cnt = 0;

  always #2 clk = ~clk;

  function automatic int floor_root(input int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // Advance the window by one pixel; return 1 when a result follows
  function automatic bit sobel_predict(input logic [7:0] pin, input bit fs, output grad_t g);
    int w, h, row, col, gx, gy, k;
    logic [7:0] p;
    w = width_reg < 3 ? 3 : (width_reg > 1024 ? 1024 : width_reg);
    h = height_reg < 3 ? 3 : height_reg;
    p = pin;
    g = '{default: '0};
    if (fs) begin
      row = 0;
      col = 0;
    end else begin
      row = row_cnt;
      col = col_cnt;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
    end
    if (border_reg && (row == 0 || row == h - 1 || col == 0 || col == w - 1)) p = '0;
    for (k = 0; k < 2; k++) begin
      win[0][k] = win[0][k+1];
      win[1][k] = win[1][k+1];
      win[2][k] = win[2][k+1];
    end
    win[0][2] = line_top[col];
    win[1][2] = line_mid[col];
    win[2][2] = p;
    line_top[col] = line_mid[col];
    line_mid[col] = p;
    col_cnt = col + 1;
    row_cnt = row;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    if (row < 2 || col < 2) return 1'b0;
    gx = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0])
       - int'(win[0][2]) - 2 * int'(win[1][2]) - int'(win[2][2]);
    gy = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
       - int'(win[2][0]) - 2 * int'(win[2][1]) - int'(win[2][2]);
    g.gx  = gx[10:0];
    g.gy  = gy[10:0];
    g.mag = 11'(floor_root(gx * gx + gy * gy));
    g.row = 12'(row - 1);
    g.col = 10'(col - 1);
    return 1'b1;
  endfunction

  // Pixel driver: hold while stalled, insert the drawn gap, then offer the next
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
      pix_gap = 0;
    end else if (!(pix_ch.valid && !pix_ch.ready)) begin
      if (pix_gap > 0) begin
        pix_ch.valid <= 1'b0;
        pix_gap--;
      end else if (pixel_q.size() > 0) begin
        pixel_t it;
        it = pixel_q.pop_front();
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= it.px;
        pix_ch.frame_start <= it.fs;
        pix_gap = quiet ? 0 : $urandom_range(0, 11);
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted pixel transaction
  always @(posedge clk) begin
    grad_t g;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (sobel_predict(pix_ch.pixel_value, pix_ch.frame_start, g)) grad_q.push_back(g);
    end
  end

  // Result monitor: check each transaction, then draw the next stall
  always @(posedge clk) begin
    grad_t e;
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_stall = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (grad_q.size() == 0) begin
          errors++;
          $display("%0t: result with none pending, gx=%0d gy=%0d", $time,
                   res_ch.grad_x, res_ch.grad_y);
        end else begin
          e = grad_q.pop_front();
          if (res_ch.grad_x !== e.gx) begin
            errors++;
            $display("%0t: grad_x expected %0d actual %0d", $time, e.gx, res_ch.grad_x);
          end
          if (res_ch.grad_y !== e.gy) begin
            errors++;
            $display("%0t: grad_y expected %0d actual %0d", $time, e.gy, res_ch.grad_y);
          end
          if (res_ch.magnitude !== e.mag) begin
            errors++;
            $display("%0t: magnitude expected %0d actual %0d", $time, e.mag, res_ch.magnitude);
          end
          if (res_ch.centre_row !== e.row) begin
            errors++;
            $display("%0t: centre_row expected %0d actual %0d", $time, e.row,
                     res_ch.centre_row);
          end
          if (res_ch.centre_col !== e.col) begin
            errors++;
            $display("%0t: centre_col expected %0d actual %0d", $time, e.col,
                     res_ch.centre_col);
          end
        end
        res_stall = quiet ? 0 : $urandom_range(0, 11);
      end else if (res_stall > 0) begin
        res_stall--;
      end
      res_ch.ready <= (res_stall == 0) && !hold;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[11:0];
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = value & 'h7FF;
      REG_IMAGE_HEIGHT: height_reg = value & 'hFFF;
      default:          border_reg = value[0];
    endcase
  endtask

  task automatic wait_drained();
    while (pixel_q.size() > 0 || pix_ch.valid || grad_q.size() > 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic push_pixel(input logic [7:0] px, input bit fs);
    pixel_q.push_back('{px: px, fs: fs});
  endtask

  function automatic logic [7:0] rand_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Queue one phase of random frames; frame starts appear rarely as noise
  task automatic push_random(input int count, input bit lead_fs);
    for (int i = 0; i < count; i++) begin
      push_pixel(rand_pixel(), (i == 0 && lead_fs) || ($urandom_range(0, 39) == 0));
    end
  endtask

  initial begin
    int prev_w, w;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_value = '0;
    pix_ch.frame_start = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_IMAGE_WIDTH;
    cfg_ch.data = '0;
    for (int i = 0; i < 1024; i++) begin
      line_top[i] = '0;
      line_mid[i] = '0;
    end
    for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win[r][c] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: 3x3 frames with extreme columns and rows, no border zeroing
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(REG_ZERO_BORDER, 0);
    for (int i = 0; i < 9; i++) push_pixel((i % 3 == 0) ? 8'hFF : 8'h00, i == 0);
    for (int i = 0; i < 9; i++) push_pixel((i % 3 == 2 || i >= 6) ? 8'hFF : 8'h00, 1'b0);
    for (int i = 0; i < 4; i++) push_pixel(8'hFF, 1'b0);
    for (int i = 0; i < 9; i++) push_pixel((i < 3) ? 8'hFF : 8'h00, i == 0);
    wait_drained();

    // Clamped low width and height, border zeroing on
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_ZERO_BORDER, 1);
    push_random(60, 1'b1);
    wait_drained();

    // Tallest frame; receiver holds off so the block backs up
    write_reg(REG_IMAGE_WIDTH, 5);
    write_reg(REG_IMAGE_HEIGHT, 4095);
    write_reg(REG_ZERO_BORDER, 0);
    fork
      begin
        hold <= 1'b1;
        repeat (400) @(posedge clk);
        hold <= 1'b0;
      end
    join_none
    push_random(80, 1'b1);
    wait_drained();

    // Widest row, clamped from above, three rows
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(REG_ZERO_BORDER, 1);
    push_random(100, 1'b1);
    wait_drained();

    // Small random shapes; a narrower width may continue without a frame start
    prev_w = 1024;
    for (int ph = 0; ph < 7; ph++) begin
      w = $urandom_range(3, 16);
      quiet = (ph == 3);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, $urandom_range(3, 8));
      write_reg(REG_ZERO_BORDER, $urandom_range(0, 1));
      push_random(40, !(w < prev_w && $urandom_range(0, 1)));
      wait_drained();
      prev_w = w;
    end
    quiet = 1'b0;

    if (errors == 0) begin
      $display("sobel_gradient_magnitude_top_tb: done, clean");
    end else begin
      $display("sobel_gradient_magnitude_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("sobel_gradient_magnitude_top_tb: done, errors");
    $finish;
  end

endmodule
